/* hdl/pis_pkg.sv */
// Shared types, constants and the quadrature phase table of the panel input scanner.
package pis_pkg;

	localparam int NUM_BUTTONS    = 38;
	localparam int NUM_ENCODERS   = 4;
	localparam int SKIPPED_BUTTON = 11;

	// Widths fixed by the transaction fields.
	localparam int PIN_W       = 38;
	localparam int ENC_PIN_W   = 8;
	localparam int ENC_PINS    = 4;
	localparam int COUNT_W     = 8;
	localparam int DEB_W       = 3;
	localparam int PERIOD_W    = 8;
	localparam int CFG_DATA_W  = 38;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 72;

	localparam logic [CFG_DATA_W-1:0] ACTIVE_LOW_RESET = CFG_DATA_W'(38'hF7FF);
	localparam logic [PERIOD_W-1:0]   PERIOD_RESET     = 8'd50;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'h7F;
	localparam logic [COUNT_W-1:0] COUNT_MIN = 8'h81;
	localparam logic [DEB_W-1:0]   DEB_MAX   = 3'd7;

	localparam logic [7:0] MARK_UP   = 8'h10;
	localparam logic [7:0] MARK_DOWN = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LOW_MASK = 1'b0,
		REG_REPORT_PERIOD   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic sample;
		logic clear;
	} enc_ctl_t;

	typedef logic [NUM_ENCODERS-1:0][COUNT_W-1:0] enc_counts_t;

	// Rows are phases 0..4, columns the AB pair; low three bits are the next phase.
	localparam logic [7:0] PHASE_TABLE [20] = '{
		8'h00, 8'h04, 8'h01, 8'h00,
		8'h02, 8'h04, 8'h01, 8'h00,
		8'h02, 8'h14, 8'h01, 8'h00,
		8'h03, 8'h04, 8'h21, 8'h00,
		8'h03, 8'h04, 8'h01, 8'h00
	};

	function automatic logic [7:0] phase_step(input logic [2:0] ph, input logic [1:0] pair);
		logic [2:0] p;
		p = (ph > 3'd4) ? 3'd0 : ph;
		return PHASE_TABLE[{p, pair}];
	endfunction

endpackage

/* hdl/panel_input_scanner.sv */
// Top level of the panel input scanner: stream ports, tick counter and report register.
//
//  Channel   Direction  Transaction carries
//  s_*       in         tuser: opcode; tdata: encoder_pins, button_pins
//  m_*       out        tdata: enc_count_0..3, buttons_pressed
//  cfg_*     in         one register write per cycle with cfg_we high
//
// One transaction is accepted per cycle for as long as the result side keeps up.
// An accepted transaction is held in the input register until the result side has room;
// the update of the encoder, debounce and tick state and the report decision are made
// as it leaves, and a report then sits in the result register that drives m_tvalid.
// Reset clears all but the data registers at once; no sweep follows. A stalled result
// blocks the input register only when the register also holds a transaction, so
// s_tready drops only while both are full and m_tready is low.
module panel_input_scanner (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] encoder_pins, [45:8] button_pins, [47:46] zero
	input  logic [pis_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] opcode
	input  logic                            s_tuser,

	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] enc_count_0, [15:8] enc_count_1, [23:16] enc_count_2,
	// [31:24] enc_count_3, [69:32] buttons_pressed, [71:70] zero
	output logic [pis_pkg::OUT_DATA_W-1:0]  m_tdata,

	input  logic                            cfg_we,
	input  logic [pis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pis_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pis_pkg::*;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] active_low_mask_q;
	logic [PERIOD_W-1:0]   report_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_mask_q <= ACTIVE_LOW_RESET;
			report_period_q   <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_LOW_MASK: active_low_mask_q <= cfg_data;
				REG_REPORT_PERIOD:   report_period_q   <= cfg_data[PERIOD_W-1:0];
				default:             ;
			endcase
		end
	end

	// Input register. It advances whenever the result register has room, so a
	// transaction is taken every cycle while the downstream side accepts.
	logic                 valid_s1;
	logic                 op_s1;
	logic [IN_DATA_W-1:0] data_s1;
	logic                 adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	logic is_tick;
	logic is_sample;
	assign is_tick   = adv && op_s1;
	assign is_sample = adv && !op_s1;

	// Report timing: the tick counter is stepped first, and a report check
	// happens when the new value exceeds the period. An 8-bit counter wraps,
	// so a period of 255 never reports.
	logic [PERIOD_W-1:0] tick_q;
	logic [PERIOD_W-1:0] tick_nxt;
	logic                report;

	assign tick_nxt = tick_q + 8'd1;
	assign report   = tick_nxt > report_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (is_tick) begin
			tick_q <= report ? '0 : tick_nxt;
		end
	end

	// Encoders: counts are read out and cleared on a reporting tick.
	enc_ctl_t    enc_ctl;
	enc_counts_t enc_counts;

	assign enc_ctl.sample = is_sample;
	assign enc_ctl.clear  = is_tick && report;

	pis_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (enc_ctl),
		.pins   (data_s1[ENC_PIN_W-1:0]),
		.counts (enc_counts)
	);

	// Buttons: pressed_nxt reflects the counters after this tick's step.
	logic [NUM_BUTTONS-1:0] pressed_nxt;
	logic [NUM_BUTTONS-1:0] last_q;

	pis_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (is_tick),
		.pins        (data_s1[ENC_PIN_W +: PIN_W]),
		.mask        (active_low_mask_q),
		.pressed_nxt (pressed_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (is_tick && report) begin
			last_q <= pressed_nxt;
		end
	end

	// Result assembly. Encoder fields without an encoder read as zero, and the
	// pressed vector is fitted to the 38-bit field.
	logic [ENC_PINS-1:0][COUNT_W-1:0] enc_field;
	logic [PIN_W-1:0]                 btn_field;

	genvar k;
	generate
		for (k = 0; k < ENC_PINS; k++) begin : g_encf
			if (k < NUM_ENCODERS) begin : g_have
				assign enc_field[k] = enc_counts[k];
			end else begin : g_none
				assign enc_field[k] = '0;
			end
		end
		for (k = 0; k < PIN_W; k++) begin : g_btnf
			if (k < NUM_BUTTONS) begin : g_have
				assign btn_field[k] = pressed_nxt[k];
			end else begin : g_none
				assign btn_field[k] = 1'b0;
			end
		end
	endgenerate

	// A report goes out only when something moved or the buttons changed.
	logic emit;
	assign emit = is_tick && report && ((|enc_counts) || (pressed_nxt != last_q));

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {2'b00, btn_field, enc_field};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// The input side stalls only when both registers are full and the result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a waiting result");

	// A new result can only follow a tick that reached the report threshold.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(is_tick && report))
		else $error("result raised without a reporting tick");

	// A reporting tick restarts the period count.
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && report) |=> (tick_q == '0))
		else $error("tick counter not cleared after report");

	// Encoder counts are empty right after a report check.
	a_enc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && report) |=> (enc_counts == '0))
		else $error("encoder counts not cleared after report");

	// The unsampled button never reads as pressed.
	a_skip_btn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[2*ENC_PINS*4 + SKIPPED_BUTTON])
		else $error("unsampled button reported as pressed");

endmodule

/* hdl/pis_quad.sv */
// Quadrature decoders: per-encoder phase tracking and saturating step counts.
module pis_quad (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pis_pkg::enc_ctl_t             ctl,
	input  logic [pis_pkg::ENC_PIN_W-1:0] pins,
	output pis_pkg::enc_counts_t          counts
);
	import pis_pkg::*;

	genvar k;
	generate
		for (k = 0; k < NUM_ENCODERS; k++) begin : g_enc
			logic [2:0]         phase_q;
			logic [COUNT_W-1:0] count_q;
			logic [1:0]         pair;
			logic [7:0]         nxt;

			if (k < ENC_PINS) begin : g_pins
				assign pair = pins[2*k +: 2];
			end else begin : g_nopins
				assign pair = 2'b00;
			end

			assign nxt = phase_step(phase_q, pair);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					phase_q <= 3'd0;
					count_q <= '0;
				end else if (ctl.clear) begin
					count_q <= '0;
				end else if (ctl.sample) begin
					phase_q <= nxt[2:0];
					if ((nxt & MARK_UP) != 8'd0 && count_q != COUNT_MAX) begin
						count_q <= count_q + 8'd1;
					end else if ((nxt & MARK_DOWN) != 8'd0 && count_q != COUNT_MIN) begin
						count_q <= count_q - 8'd1;
					end
				end
			end

			assign counts[k] = count_q;
		end
	endgenerate

endmodule

/* hdl/pis_debounce.sv */
// Integrating debounce counters, one per sampled button, stepped on each tick.
module pis_debounce (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  logic [pis_pkg::PIN_W-1:0]       pins,
	input  logic [pis_pkg::CFG_DATA_W-1:0]  mask,
	output logic [pis_pkg::NUM_BUTTONS-1:0] pressed_nxt
);
	import pis_pkg::*;

	genvar n;
	generate
		for (n = 0; n < NUM_BUTTONS; n++) begin : g_btn
			if (n == SKIPPED_BUTTON || n >= PIN_W) begin : g_idle
				// This button has no sampled pin; it never reads as pressed.
				assign pressed_nxt[n] = 1'b0;
			end else begin : g_cnt
				logic [DEB_W-1:0] cnt_q;
				logic [DEB_W-1:0] cnt_nxt;
				logic             active;

				assign active = pins[n] ^ mask[n];

				always_comb begin
					if (active) begin
						cnt_nxt = (cnt_q == DEB_MAX) ? cnt_q : cnt_q + 3'd1;
					end else begin
						cnt_nxt = (cnt_q == 3'd0) ? cnt_q : cnt_q - 3'd1;
					end
				end

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						cnt_q <= '0;
					end else if (tick) begin
						cnt_q <= cnt_nxt;
					end
				end

				// Pressed at a count of four or more.
				assign pressed_nxt[n] = cnt_nxt[2];
			end
		end
	endgenerate

endmodule
